### design/vts_pkg.sv
// Shared constants, types and command/status structs of the top-k search unit.
package vts_pkg;
   localparam int MaxDocs = 256;
   localparam int MaxDim = 128;
   localparam int MaxTopK = 16;
   localparam int SlotW = $clog2(MaxDocs);
   localparam int DimW = $clog2(MaxDim);
   localparam int KW = $clog2(MaxTopK);
   localparam int CntW = $clog2(MaxTopK + 1);
   localparam int VecAw = SlotW + DimW;

   localparam logic [1:0] ReqDocWrite = 2'd0;
   localparam logic [1:0] ReqDelete = 2'd1;
   localparam logic [1:0] ReqQuery = 2'd2;
   localparam logic [1:0] ReqUnused = 2'd3;

   localparam logic [1:0] CsrVectorLength = 2'd0;
   localparam logic [1:0] CsrResultLimit = 2'd1;
   localparam logic [1:0] CsrScoreFloor = 2'd2;

   typedef struct packed {
      logic [1:0] req_type;
      logic [7:0] slot;
      logic [6:0] elem_index;
      logic signed [15:0] value;
      logic signed [31:0] doc_key;
   } req_type_t_type;

   typedef struct packed {
      logic signed [31:0] hit_key;
      logic signed [31:0] hit_score;
      logic found;
      logic last;
   } rsp_type;

   typedef struct packed {
      logic [1:0] reg_index;
      logic [31:0] data;
   } csr_type;

   // Controller to datapath.
   typedef struct packed {
      logic store_beat;     // Write the accepted beat into doc or query storage.
      logic clear_best;     // Start a new query.
      logic mac_clear;      // Clear accumulator.
      logic mac_en;         // Read the scan elements and accumulate their product.
      logic offer;          // Offer current accumulator for current slot.
      logic live_check;     // Latch live bit of scan slot.
      logic [SlotW-1:0] scan_slot;
      logic [DimW-1:0] scan_elem;
      logic [KW-1:0] out_idx;
      logic out_empty;
      logic out_last;
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic [CntW-1:0] best_count;
      logic slot_live;
   } sts_type;

   function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
      logic signed [32:0] s;
      s = {a[31], a} + {b[31], b};
      if (s > 33'sd2147483647) return 32'h7FFF_FFFF;
      else if (s < -33'sd2147483648) return 32'h8000_0000;
      else return s[31:0];
   endfunction
endpackage

### design/vts_if.sv
// Valid/ready channel interfaces for request, response and register writes.
interface vts_req_if;
   logic valid;
   logic ready;
   vts_pkg::req_type_t_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface vts_rsp_if;
   logic valid;
   logic ready;
   vts_pkg::rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface vts_csr_if;
   logic valid;
   logic ready;
   vts_pkg::csr_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

### design/vts_ram.sv
// Generic single-port-write, registered-read RAM.
module vts_ram #(
   parameter int Width = 16,
   parameter int Depth = 256
) (
   input logic clock,
   input logic wr_en,
   input logic [$clog2(Depth)-1:0] wr_addr,
   input logic [Width-1:0] wr_data,
   input logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0] rd_data
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

### design/vts_datapath.sv
// Storage, multiply-accumulate, top-k list and result formatting.
module vts_datapath (
   input logic clock,
   input logic reset,
   input vts_pkg::req_type_t_type req,
   input logic [vts_pkg::DimW-1:0] len_m1,
   input logic [vts_pkg::CntW-1:0] limit,
   input logic signed [31:0] floor_v,
   input vts_pkg::cmd_type cmd,
   output vts_pkg::sts_type sts,
   output vts_pkg::rsp_type rsp
);
   logic doc_wr, qry_wr, in_range_slot, in_range_elem;
   logic [vts_pkg::VecAw-1:0] doc_waddr, doc_raddr;
   logic signed [15:0] doc_rd, qry_rd;
   logic [31:0] key_rd;
   logic [vts_pkg::MaxDocs-1:0] live_ff, live_in;
   logic live_ff_q_ff;
   logic signed [31:0] prod_ff, acc_ff;
   logic rd_v_ff, prod_v_ff;
   logic signed [31:0] bs_ff [vts_pkg::MaxTopK];
   logic signed [31:0] bk_ff [vts_pkg::MaxTopK];
   logic [vts_pkg::CntW-1:0] cnt_ff, cnt_in, eff_cnt;
   logic accept;

   assign in_range_slot = ({1'b0, req.slot} < 9'(vts_pkg::MaxDocs));
   assign in_range_elem = ({1'b0, req.elem_index} < 8'(vts_pkg::MaxDim));
   assign doc_wr = cmd.store_beat && req.req_type == vts_pkg::ReqDocWrite
                   && in_range_slot && in_range_elem;
   assign qry_wr = cmd.store_beat && req.req_type == vts_pkg::ReqQuery && in_range_elem;
   assign doc_waddr = {req.slot[vts_pkg::SlotW-1:0], req.elem_index[vts_pkg::DimW-1:0]};
   assign doc_raddr = {cmd.scan_slot, cmd.scan_elem};

   vts_ram #(.Width(16), .Depth(vts_pkg::MaxDocs * vts_pkg::MaxDim)) u_doc (
      .clock, .wr_en(doc_wr), .wr_addr(doc_waddr), .wr_data(req.value),
      .rd_addr(doc_raddr), .rd_data(doc_rd));
   vts_ram #(.Width(32), .Depth(vts_pkg::MaxDocs)) u_key (
      .clock, .wr_en(doc_wr), .wr_addr(req.slot[vts_pkg::SlotW-1:0]), .wr_data(req.doc_key),
      .rd_addr(cmd.scan_slot), .rd_data(key_rd));
   vts_ram #(.Width(16), .Depth(vts_pkg::MaxDim)) u_qry (
      .clock, .wr_en(qry_wr), .wr_addr(req.elem_index[vts_pkg::DimW-1:0]),
      .wr_data(req.value), .rd_addr(cmd.scan_elem), .rd_data(qry_rd));

   always_comb begin
      live_in = live_ff;
      if (doc_wr && req.elem_index[vts_pkg::DimW-1:0] == len_m1)
         live_in[req.slot[vts_pkg::SlotW-1:0]] = 1'b1;
      if (cmd.store_beat && req.req_type == vts_pkg::ReqDelete && in_range_slot)
         live_in[req.slot[vts_pkg::SlotW-1:0]] = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff <= '0;
         live_ff_q_ff <= 1'b0;
      end else begin
         live_ff <= live_in;
         if (cmd.live_check) live_ff_q_ff <= live_ff[cmd.scan_slot];
      end
   end
   assign sts.slot_live = live_ff_q_ff;

   // Memory read, product register, then saturating accumulate.
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_v_ff <= 1'b0;
         prod_v_ff <= 1'b0;
      end else begin
         rd_v_ff <= cmd.mac_en;
         prod_v_ff <= rd_v_ff;
      end
      prod_ff <= 32'(qry_rd * doc_rd);
      if (cmd.mac_clear) acc_ff <= '0;
      else if (prod_v_ff) acc_ff <= vts_pkg::sat_add(acc_ff, prod_ff);
   end

   // Top-k insertion: all entries shift in parallel.
   assign accept = cmd.offer && acc_ff >= floor_v && limit != '0
                   && (cnt_ff < limit || acc_ff > bs_ff[vts_pkg::KW'(limit - 1'b1)]);
   assign eff_cnt = (cnt_ff >= limit) ? limit - 1'b1 : cnt_ff;

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.clear_best) cnt_in = '0;
      else if (accept) cnt_in = eff_cnt + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) cnt_ff <= '0;
      else cnt_ff <= cnt_in;
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         for (int i = 0; i < vts_pkg::MaxTopK; i++) begin
            if (i < 32'(eff_cnt) + 1) begin
               if (i == 0 ? 1'b0 : bs_ff[i-1] < acc_ff) begin
                  if (bs_ff[i] >= acc_ff && i < 32'(eff_cnt)) begin
                  end else begin
                     bs_ff[i] <= bs_ff[i-1];
                     bk_ff[i] <= bk_ff[i-1];
                  end
               end
               if ((i == 32'(eff_cnt) || bs_ff[i] < acc_ff)
                   && (i == 0 || bs_ff[i-1] >= acc_ff)) begin
                  bs_ff[i] <= acc_ff;
                  bk_ff[i] <= key_rd;
               end
            end
         end
      end
   end
   assign sts.best_count = cnt_ff;

   always_comb begin
      rsp.hit_key = cmd.out_empty ? '0 : bk_ff[cmd.out_idx];
      rsp.hit_score = cmd.out_empty ? '0 : bs_ff[cmd.out_idx];
      rsp.found = !cmd.out_empty;
      rsp.last = cmd.out_last;
   end
endmodule

### design/vts_ctrl.sv
// Sequencer for request intake, slot scan and result emission.
module vts_ctrl (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   input vts_pkg::req_type_t_type req,
   input logic [vts_pkg::DimW-1:0] len_m1,
   input vts_pkg::sts_type sts,
   output vts_pkg::cmd_type cmd,
   output logic rsp_load,
   input logic rsp_free
);
   localparam logic [2:0] StIdle = 3'd0;
   localparam logic [2:0] StLive = 3'd1;
   localparam logic [2:0] StMac = 3'd2;
   localparam logic [2:0] StDrain = 3'd3;
   localparam logic [2:0] StOffer = 3'd4;
   localparam logic [2:0] StEmit = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [vts_pkg::SlotW:0] slot_ff, slot_in;
   logic [vts_pkg::DimW:0] elem_ff, elem_in;
   logic [1:0] drain_ff, drain_in;
   logic [vts_pkg::CntW-1:0] oi_ff, oi_in;
   logic accept, completes;

   assign req_ready = state_ff == StIdle;
   assign accept = req_valid && req_ready;
   assign completes = req.req_type == vts_pkg::ReqQuery
                      && {1'b0, req.elem_index} < 8'(vts_pkg::MaxDim)
                      && req.elem_index[vts_pkg::DimW-1:0] == len_m1;

   always_comb begin
      state_in = state_ff;
      slot_in = slot_ff;
      elem_in = elem_ff;
      drain_in = drain_ff;
      oi_in = oi_ff;
      cmd = '0;
      cmd.scan_slot = slot_ff[vts_pkg::SlotW-1:0];
      cmd.scan_elem = elem_ff[vts_pkg::DimW-1:0];
      cmd.out_idx = oi_ff[vts_pkg::KW-1:0];
      cmd.out_empty = sts.best_count == '0;
      cmd.out_last = cmd.out_empty || oi_ff + 1'b1 == sts.best_count;
      rsp_load = 1'b0;
      unique case (state_ff)
         StIdle: begin
            cmd.store_beat = accept;
            if (accept && completes) begin
               cmd.clear_best = 1'b1;
               slot_in = '0;
               state_in = StLive;
            end
         end
         StLive: begin
            cmd.live_check = 1'b1;
            cmd.mac_clear = 1'b1;
            elem_in = '0;
            state_in = StMac;
         end
         StMac: begin
            if (!sts.slot_live) begin
               state_in = StOffer;
            end else begin
               cmd.mac_en = 1'b1;
               if (elem_ff[vts_pkg::DimW-1:0] == len_m1) begin
                  drain_in = '0;
                  state_in = StDrain;
               end else begin
                  elem_in = elem_ff + 1'b1;
               end
            end
         end
         StDrain: begin
            drain_in = drain_ff + 1'b1;
            if (drain_ff == 2'd2) begin
               cmd.offer = 1'b1;
               state_in = StOffer;
            end
         end
         StOffer: begin
            if (slot_ff == (vts_pkg::SlotW + 1)'(vts_pkg::MaxDocs - 1)) begin
               oi_in = '0;
               state_in = StEmit;
            end else begin
               slot_in = slot_ff + 1'b1;
               state_in = StLive;
            end
         end
         StEmit: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               oi_in = oi_ff + 1'b1;
               if (cmd.out_last) state_in = StIdle;
            end
         end
         default: state_in = StIdle;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= StIdle;
         slot_ff <= '0;
         elem_ff <= '0;
         drain_ff <= '0;
         oi_ff <= '0;
      end else begin
         state_ff <= state_in;
         slot_ff <= slot_in;
         elem_ff <= elem_in;
         drain_ff <= drain_in;
         oi_ff <= oi_in;
      end
   end
endmodule

### design/vector_topk_similarity_search_unit.sv
// Top level of the brute-force dot-product top-k similarity search unit.
//  channel  dir  payload
//  req_     in   req_type, slot, elem_index, value, doc_key
//  rsp_     out  hit_key, hit_score, found, last
//  csr_     in   reg_index, data
// Non-completing beats are stored as they are accepted. A completing query element scans all 256
// slots with the single multiply-accumulate unit, which skips the products of a dead slot,
// then emits the results as response beats while the output register is free.
// Reset is synchronous and clears live bits, registers and control.
// A stalled response holds in the output register; requests wait until the query ends.
module vector_topk_similarity_search_unit (
   input logic clock,
   input logic reset,
   vts_req_if.sink req,
   vts_rsp_if.source rsp,
   vts_csr_if.sink csr
);
   logic [7:0] vlen_ff;
   logic [4:0] limit_ff;
   logic signed [31:0] floor_ff;
   logic [vts_pkg::DimW-1:0] len_m1;
   logic [vts_pkg::CntW-1:0] limit_eff;
   vts_pkg::cmd_type cmd;
   vts_pkg::sts_type sts;
   vts_pkg::rsp_type rsp_d, rsp_ff;
   logic rsp_v_ff, rsp_load, rsp_free;

   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         vlen_ff <= 8'd128;
         limit_ff <= 5'd16;
         floor_ff <= 32'h8000_0000;
      end else if (csr.valid) begin
         unique case (csr.data.reg_index)
            vts_pkg::CsrVectorLength: vlen_ff <= csr.data.data[7:0];
            vts_pkg::CsrResultLimit: limit_ff <= csr.data.data[4:0];
            vts_pkg::CsrScoreFloor: floor_ff <= csr.data.data;
            default: ;
         endcase
      end
   end

   always_comb begin
      if (vlen_ff == 8'd0) len_m1 = '0;
      else if (vlen_ff > 8'(vts_pkg::MaxDim)) len_m1 = vts_pkg::DimW'(vts_pkg::MaxDim - 1);
      else len_m1 = vts_pkg::DimW'(vlen_ff - 8'd1);
      limit_eff = (limit_ff > 5'(vts_pkg::MaxTopK)) ? vts_pkg::CntW'(vts_pkg::MaxTopK)
                                                    : vts_pkg::CntW'(limit_ff);
   end

   vts_ctrl u_ctrl (
      .clock, .reset, .req_valid(req.valid), .req_ready(req.ready), .req(req.data),
      .len_m1, .sts, .cmd, .rsp_load, .rsp_free);

   vts_datapath u_dp (
      .clock, .reset, .req(req.data), .len_m1, .limit(limit_eff), .floor_v(floor_ff),
      .cmd, .sts, .rsp(rsp_d));

   assign rsp_free = !rsp_v_ff || rsp.ready;
   always_ff @(posedge clock) begin
      if (reset) rsp_v_ff <= 1'b0;
      else if (rsp_load) rsp_v_ff <= 1'b1;
      else if (rsp.ready) rsp_v_ff <= 1'b0;
      if (rsp_load) rsp_ff <= rsp_d;
   end
   assign rsp.valid = rsp_v_ff;
   assign rsp.data = rsp_ff;
endmodule
